### design/kvs_pkg.sv
package kvs_pkg;

   localparam int unsigned KEY_W = 64;
   localparam int unsigned VAL_W = 64;
   localparam int unsigned SEQ_W = 7;
   localparam logic [KEY_W-1:0] SIGN_BIT = {1'b1, {(KEY_W-1){1'b0}}};

   localparam logic [0:0] REG_VALUES_ENABLED = 1'b0;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] val;
      logic [SEQ_W-1:0] seq;
   } pair_type;

   typedef enum logic [0:0] {
      ST_LOAD,
      ST_DRAIN
   } state_type;

   function automatic logic [KEY_W-1:0] order_of(input logic [KEY_W-1:0] bits);
      logic [KEY_W-1:0] b;
      b = (bits == SIGN_BIT) ? '0 : bits;
      if (b[KEY_W-1]) begin
         return ~b;
      end
      return b | SIGN_BIT;
   endfunction

endpackage

### design/key_value_sorter_core.sv
// Channel  | Ports                                        | Direction
// req      | req_valid req_stall req_sort_key req_payload | in
//          | req_final_item                               |
// rsp      | rsp_valid rsp_stall rsp_out_key rsp_out_payload | out
//          | rsp_end_of_set rsp_dropped                   |
// csr      | psel penable pwrite paddr pwdata prdata pready | APB
//
// Load: one pair per cycle enters the insertion chain.
// Drain: after the final pair the insertion chain settles, then one
// result per cycle leaves slot 0 while rsp_stall is low.
// req_stall is high during settle and drain; the input reopens once the
// last result of the set has been taken.
// Reset is synchronous and empties every cell; values_enabled resets to 1.
module key_value_sorter_core #(
   parameter int unsigned CAPACITY = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [kvs_pkg::KEY_W-1:0] req_sort_key,
   input  logic [kvs_pkg::VAL_W-1:0] req_payload,
   input  logic                      req_final_item,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [kvs_pkg::KEY_W-1:0] rsp_out_key,
   output logic [kvs_pkg::VAL_W-1:0] rsp_out_payload,
   output logic                      rsp_end_of_set,
   output logic                      rsp_dropped,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [1:0]                csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);

   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam int unsigned SW = $clog2(CAPACITY + 2);
   localparam int unsigned QW = kvs_pkg::SEQ_W;

   kvs_pkg::state_type state_ff, state_in;
   logic [CW-1:0]      fill_ff, fill_in;
   logic [SW-1:0]      settle_ff, settle_in;
   logic               ovf_ff, ovf_in;
   logic               ven_ff;
   logic               take, fire, load, drain, clear, pop;

   kvs_pkg::pair_type  c_in [CAPACITY];
   logic               c_iv [CAPACITY];
   kvs_pkg::pair_type  c_out [CAPACITY];
   logic               c_ov [CAPACITY];
   kvs_pkg::pair_type  c_held [CAPACITY+1];
   logic               c_hv [CAPACITY+1];

   assign csr_pready = 1'b1;
   assign csr_prdata = {31'd0, ven_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         ven_ff <= 1'b1;
      end else if (csr_psel && csr_penable && csr_pwrite
                   && csr_paddr[1:0] == {kvs_pkg::REG_VALUES_ENABLED, 1'b0}) begin
         ven_ff <= csr_pwdata[0];
      end
   end

   assign take  = req_valid && !req_stall;
   assign load  = take && (fill_ff < CW'(CAPACITY));
   assign fire  = (state_ff == kvs_pkg::ST_DRAIN) && (settle_ff == '0);
   assign pop   = fire && rsp_valid && !rsp_stall;
   assign drain = pop;
   assign clear = 1'b0;
   assign req_stall = (state_ff != kvs_pkg::ST_LOAD);

   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      settle_in = settle_ff;
      ovf_in    = ovf_ff;
      case (state_ff)
         kvs_pkg::ST_LOAD: begin
            if (take) begin
               if (load) begin
                  fill_in = fill_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_final_item) begin
                  state_in  = kvs_pkg::ST_DRAIN;
                  settle_in = SW'(CAPACITY);
               end
            end
         end
         kvs_pkg::ST_DRAIN: begin
            if (settle_ff != '0) begin
               settle_in = settle_ff - 1'b1;
            end else if (pop) begin
               fill_in = fill_ff - 1'b1;
               if (fill_ff == CW'(1)) begin
                  state_in = kvs_pkg::ST_LOAD;
                  ovf_in   = 1'b0;
               end
            end
         end
         default: state_in = kvs_pkg::ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= kvs_pkg::ST_LOAD;
         fill_ff   <= '0;
         settle_ff <= '0;
         ovf_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         settle_ff <= settle_in;
         ovf_ff    <= ovf_in;
      end
   end

   assign c_held[CAPACITY] = '0;
   assign c_hv[CAPACITY]   = 1'b0;

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      if (g == 0) begin : g_head
         assign c_in[g] = '{key: req_sort_key, val: req_payload, seq: QW'(fill_ff)};
         assign c_iv[g] = load;
      end else begin : g_body
         assign c_in[g] = c_out[g-1];
         assign c_iv[g] = c_ov[g-1];
      end
      kvs_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .load      (1'b1),
         .drain     (drain),
         .clear     (clear),
         .in_pair   (c_in[g]),
         .in_valid  (c_iv[g]),
         .up_pair   (c_held[g+1]),
         .up_valid  (c_hv[g+1]),
         .out_pair  (c_out[g]),
         .out_valid (c_ov[g]),
         .held_pair (c_held[g]),
         .held_valid(c_hv[g])
      );
   end

   assign rsp_valid       = fire && c_hv[0];
   assign rsp_out_key     = c_held[0].key;
   assign rsp_out_payload = ven_ff ? c_held[0].val : '0;
   assign rsp_end_of_set  = (fill_ff == CW'(1));
   assign rsp_dropped     = ovf_ff;

   a_no_req_in_drain: assert property (@(posedge clock) disable iff (reset)
      state_ff == kvs_pkg::ST_DRAIN |-> !take)
      else $error("request taken while draining");
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(CAPACITY))
      else $error("fill count beyond capacity");
   a_last_returns: assert property (@(posedge clock) disable iff (reset)
      pop && rsp_end_of_set |=> state_ff == kvs_pkg::ST_LOAD && fill_ff == '0)
      else $error("set did not close after last result");
   a_drain_has_data: assert property (@(posedge clock) disable iff (reset)
      fire |-> c_hv[0])
      else $error("drain with empty head cell");

endmodule

### design/kvs_cell.sv
// One slot of the insertion chain. Load: keep the smaller pair, pass the larger
// one up; order is key, then arrival tag, so equal keys stay in arrival order.
// Drain: shift stored pair toward slot 0.
module kvs_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  logic              drain,
   input  logic              clear,
   input  kvs_pkg::pair_type in_pair,
   input  logic              in_valid,
   input  kvs_pkg::pair_type up_pair,
   input  logic              up_valid,
   output kvs_pkg::pair_type out_pair,
   output logic              out_valid,
   output kvs_pkg::pair_type held_pair,
   output logic              held_valid
);

   kvs_pkg::pair_type pair_ff, pair_in, pass_in, pass_ff;
   logic              vld_ff, vld_in, pvld_in, pvld_ff;
   logic              keep;

   always_comb begin
      keep    = vld_ff && ({kvs_pkg::order_of(pair_ff.key), pair_ff.seq}
                           <= {kvs_pkg::order_of(in_pair.key), in_pair.seq});
      pair_in = pair_ff;
      vld_in  = vld_ff;
      pass_in = in_pair;
      pvld_in = 1'b0;
      if (clear) begin
         vld_in = 1'b0;
      end else if (drain) begin
         pair_in = up_pair;
         vld_in  = up_valid;
      end else if (load && in_valid) begin
         if (!vld_ff) begin
            pair_in = in_pair;
            vld_in  = 1'b1;
         end else if (keep) begin
            pass_in = in_pair;
            pvld_in = 1'b1;
         end else begin
            pair_in = in_pair;
            pass_in = pair_ff;
            pvld_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      pair_ff <= pair_in;
      pass_ff <= pass_in;
      if (reset) begin
         vld_ff  <= 1'b0;
         pvld_ff <= 1'b0;
      end else begin
         vld_ff  <= vld_in;
         pvld_ff <= pvld_in && !clear;
      end
   end

   assign out_pair   = pass_ff;
   assign out_valid  = pvld_ff;
   assign held_pair  = pair_ff;
   assign held_valid = vld_ff;

   a_pass_needs_full: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> $past(vld_ff))
      else $error("cell passed a pair while empty");

endmodule
